>>> rtl/session_timeout_table_unit_macros.svh
// Assertion macros for the session timeout table checker.
// Needs signals named clock and reset in the scope of each use.
`ifndef SESSION_TIMEOUT_TABLE_UNIT_MACROS_SVH
`define SESSION_TIMEOUT_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define STE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("session table assertion failed");

// next-cycle implication
`define STE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("session table assertion failed");

`endif

>>> rtl/ste_pkg.sv
// Shared constants, codes and types of the session timeout table.
// No dependencies.
package ste_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // request action codes
   localparam logic [2:0] ACT_ALLOC = 3'd0;
   localparam logic [2:0] ACT_DELETE = 3'd1;
   localparam logic [2:0] ACT_STORE = 3'd2;
   localparam logic [2:0] ACT_GET = 3'd3;
   localparam logic [2:0] ACT_TICK = 3'd4;

   // response kind codes
   localparam logic [2:0] KIND_NEW_ID = 3'd0;
   localparam logic [2:0] KIND_DELETED = 3'd1;
   localparam logic [2:0] KIND_STORE = 3'd2;
   localparam logic [2:0] KIND_GET = 3'd3;
   localparam logic [2:0] KIND_TIMEOUT = 3'd4;
   localparam logic [2:0] KIND_DONE = 3'd5;

   localparam logic [15:0] MAX_AGE_RESET = 16'd10;
   localparam logic [31:0] FIRST_ID = 32'd1;

   // request fields broadcast to every cell
   typedef struct packed {
      logic [31:0] key;
      logic [7:0]  func;
      logic [3:0]  owner;
      logic [63:0] data;
      logic [31:0] now;
      logic [15:0] max_age;
   } cell_bus_type;

   // per-cell write controls
   typedef struct packed {
      logic alloc;
      logic store;
      logic clear;
   } cell_ctl_type;

   // oldest-id search token handed down the chain
   typedef struct packed {
      logic             vld;
      logic [31:0]      id;
      logic [7:0]       func;
      logic [3:0]       owner;
      logic [IDX_W-1:0] idx;
   } carry_type;

endpackage

>>> rtl/session_timeout_table_unit.sv
// Top level of the session timeout table: request latch, control FSM,
// response register and the row of ste_cell entries. Depends on ste_pkg.
//
//  channel  dir  tdata / data                          tuser   tlast
//  req_     in   id, func, owner, handle, now          action  -
//  rsp_     out  id, func, owner, handle, found, full  kind    last
//  csr_     in   max_age                                -       -
//
// Allocate, delete, store and get are latched, then matched in parallel
// across all cells before the response is registered. A tick then walks
// the oldest-id token down the cell chain one cell per cycle, once per
// timeout and once more for the final done.
// A stalled response holds the FSM; a new request is taken while the last
// response waits. Reset is synchronous, no clearing pass.
module session_timeout_table_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [31:0] session_id, [39:32] func_code, [43:40] owner,
   // [107:44] data_handle, [139:108] now, rest zero
   input  logic [143:0]  req_tdata,
   // [2:0] action
   input  logic [2:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [31:0] result_id, [39:32] result_func, [43:40] result_owner,
   // [107:44] result_data, [108] found, [109] full_res, rest zero
   output logic [111:0]  rsp_tdata,
   // [2:0] kind
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [15:0]   csr_data
);
   import ste_pkg::*;

   localparam int CNT_W = IDX_W;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_RES} state_type;

   state_type    state_ff, state_in;
   logic [2:0]   act_ff, act_in;
   logic [31:0]  sid_ff, sid_in;
   logic [7:0]   func_ff, func_in;
   logic [3:0]   own_ff, own_in;
   logic [63:0]  data_ff, data_in;
   logic [31:0]  now_ff, now_in;
   logic [31:0]  next_id_ff, next_id_in;
   logic [15:0]  max_age_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_kind_ff, rsp_kind_in;
   logic [31:0]  rsp_id_ff, rsp_id_in;
   logic [7:0]   rsp_func_ff, rsp_func_in;
   logic [3:0]   rsp_own_ff, rsp_own_in;
   logic [63:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_found_ff, rsp_found_in;
   logic         rsp_full_ff, rsp_full_in;
   logic         rsp_last_ff, rsp_last_in;

   cell_bus_type bus;
   cell_ctl_type ctl [TABLE_ENTRIES];
   logic         take [TABLE_ENTRIES+1];
   logic [63:0]  rd [TABLE_ENTRIES+1];
   carry_type    carry [TABLE_ENTRIES+1];
   logic [TABLE_ENTRIES-1:0] hit, first_free;
   logic         any_hit;
   logic         out_free;
   logic [31:0]  id_plus;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign any_hit    = |hit;
   assign id_plus    = next_id_ff + 32'd1;

   // broadcast bus
   always_comb begin
      bus.key     = (act_ff == ACT_ALLOC) ? next_id_ff : sid_ff;
      bus.func    = func_ff;
      bus.owner   = own_ff;
      bus.data    = data_ff;
      bus.now     = now_ff;
      bus.max_age = max_age_ff;
   end

   // cell row
   assign take[0]  = 1'b0;
   assign rd[0]    = 64'd0;
   assign carry[0] = '0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      ste_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bus        (bus),
         .ctl        (ctl[i]),
         .cell_idx   (IDX_W'(i)),
         .take_in    (take[i]),
         .take_out   (take[i+1]),
         .first_free (first_free[i]),
         .hit        (hit[i]),
         .rd_in      (rd[i]),
         .rd_out     (rd[i+1]),
         .carry_in   (carry[i]),
         .carry_out  (carry[i+1])
      );
   end

   // control and response next values
   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      sid_in       = sid_ff;
      func_in      = func_ff;
      own_in       = own_ff;
      data_in      = data_ff;
      now_in       = now_ff;
      next_id_in   = next_id_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_func_in  = rsp_func_ff;
      rsp_own_in   = rsp_own_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_last_in  = rsp_last_ff;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         ctl[i] = '0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               act_in   = req_tuser;
               sid_in   = req_tdata[31:0];
               func_in  = req_tdata[39:32];
               own_in   = req_tdata[43:40];
               data_in  = req_tdata[107:44];
               now_in   = req_tdata[139:108];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (act_ff inside {ACT_ALLOC, ACT_DELETE, ACT_STORE, ACT_GET}) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_id_in    = 32'd0;
                  rsp_func_in  = 8'd0;
                  rsp_own_in   = 4'd0;
                  rsp_data_in  = 64'd0;
                  rsp_found_in = 1'b0;
                  rsp_full_in  = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
                  case (act_ff)
                     ACT_ALLOC: begin
                        rsp_kind_in = KIND_NEW_ID;
                        if (any_hit || take[TABLE_ENTRIES]) begin
                           rsp_id_in  = next_id_ff;
                           next_id_in = (id_plus == 32'd0) ? FIRST_ID : id_plus;
                           for (int i = 0; i < TABLE_ENTRIES; i++) begin
                              ctl[i].alloc = hit[i] || (!any_hit && first_free[i]);
                           end
                        end else begin
                           rsp_full_in = 1'b1;
                        end
                     end
                     ACT_DELETE: begin
                        rsp_kind_in  = KIND_DELETED;
                        rsp_found_in = any_hit;
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                           ctl[i].clear = hit[i];
                        end
                     end
                     ACT_STORE: begin
                        rsp_kind_in  = KIND_STORE;
                        rsp_found_in = any_hit;
                        for (int i = 0; i < TABLE_ENTRIES; i++) begin
                           ctl[i].store = hit[i];
                        end
                     end
                     default: begin
                        rsp_kind_in  = KIND_GET;
                        rsp_found_in = any_hit;
                        rsp_data_in  = rd[TABLE_ENTRIES];
                     end
                  endcase
               end
            end else if (act_ff == ACT_TICK) begin
               cnt_in   = '0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = 64'd0;
               rsp_found_in = 1'b0;
               rsp_full_in  = 1'b0;
               if (carry[TABLE_ENTRIES].vld) begin
                  rsp_kind_in = KIND_TIMEOUT;
                  rsp_id_in   = carry[TABLE_ENTRIES].id;
                  rsp_func_in = carry[TABLE_ENTRIES].func;
                  rsp_own_in  = carry[TABLE_ENTRIES].owner;
                  rsp_last_in = 1'b0;
                  for (int i = 0; i < TABLE_ENTRIES; i++) begin
                     ctl[i].clear = (carry[TABLE_ENTRIES].idx == IDX_W'(i));
                  end
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  rsp_kind_in = KIND_DONE;
                  rsp_id_in   = 32'd0;
                  rsp_func_in = 8'd0;
                  rsp_own_in  = 4'd0;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         next_id_ff   <= FIRST_ID;
         max_age_ff   <= MAX_AGE_RESET;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next_id_ff   <= next_id_in;
         cnt_ff       <= cnt_in;
         if (csr_valid) begin
            max_age_ff <= csr_data;
         end
      end
      act_ff       <= act_in;
      sid_ff       <= sid_in;
      func_ff      <= func_in;
      own_ff       <= own_in;
      data_ff      <= data_in;
      now_ff       <= now_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_func_ff  <= rsp_func_in;
      rsp_own_ff   <= rsp_own_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_full_ff, rsp_found_ff, rsp_data_ff,
                        rsp_own_ff, rsp_func_ff, rsp_id_ff};

endmodule

>>> rtl/ste_cell.sv
// One session entry of the table plus its share of the chains.
// Depends on ste_pkg.
module ste_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ste_pkg::cell_bus_type   bus,
   input  ste_pkg::cell_ctl_type   ctl,
   input  logic [ste_pkg::IDX_W-1:0] cell_idx,
   input  logic                    take_in,
   output logic                    take_out,
   output logic                    first_free,
   output logic                    hit,
   input  logic [63:0]             rd_in,
   output logic [63:0]             rd_out,
   input  ste_pkg::carry_type      carry_in,
   output ste_pkg::carry_type      carry_out
);
   import ste_pkg::*;

   logic        valid_ff;
   logic [31:0] id_ff;
   logic [7:0]  func_ff;
   logic [3:0]  owner_ff;
   logic [31:0] start_ff;
   logic [63:0] data_ff;
   carry_type   carry_ff;
   carry_type   carry_in_next;
   logic [31:0] age;
   logic        due;

   // lookup and free-slot priority
   assign hit        = valid_ff && (id_ff == bus.key);
   assign first_free = !valid_ff && !take_in;
   assign take_out   = take_in || !valid_ff;
   assign rd_out     = rd_in | (hit ? data_ff : 64'd0);

   // timeout test and search step
   assign age = bus.now - start_ff;
   assign due = valid_ff && (bus.now > start_ff) && (age > {16'd0, bus.max_age});

   always_comb begin
      carry_in_next = carry_in;
      if (due && (!carry_in.vld || (id_ff < carry_in.id))) begin
         carry_in_next.vld   = 1'b1;
         carry_in_next.id    = id_ff;
         carry_in_next.func  = func_ff;
         carry_in_next.owner = owner_ff;
         carry_in_next.idx   = cell_idx;
      end
   end

   assign carry_out = carry_ff;

   // valid bit and search token
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         carry_ff.vld <= 1'b0;
      end else begin
         carry_ff.vld <= carry_in_next.vld;
         if (ctl.alloc) begin
            valid_ff <= 1'b1;
         end else if (ctl.clear) begin
            valid_ff <= 1'b0;
         end
      end
      carry_ff.id    <= carry_in_next.id;
      carry_ff.func  <= carry_in_next.func;
      carry_ff.owner <= carry_in_next.owner;
      carry_ff.idx   <= carry_in_next.idx;
   end

   // entry payload
   always_ff @(posedge clock) begin
      if (ctl.alloc) begin
         id_ff    <= bus.key;
         func_ff  <= bus.func;
         owner_ff <= bus.owner;
         start_ff <= bus.now;
         data_ff  <= 64'd0;
      end else if (ctl.store) begin
         data_ff <= bus.data;
      end
   end

endmodule

>>> rtl/ste_checker.sv
// Port-level checks of the session timeout table, bound to the top level.
// Depends on ste_pkg and session_timeout_table_unit_macros.svh.
`include "session_timeout_table_unit_macros.svh"

module ste_checker (
   input logic          clock,
   input logic          reset,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [111:0]  rsp_tdata,
   input logic [2:0]    rsp_tuser,
   input logic          rsp_tlast
);
   import ste_pkg::*;

   // a stalled response stays up
   `STE_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // timeouts never close a tick, done always does
   `STE_ASSERT_IMP(a_timeout_not_last, rsp_tvalid && rsp_tuser == KIND_TIMEOUT, !rsp_tlast)
   `STE_ASSERT_IMP(a_done_last, rsp_tvalid && rsp_tuser == KIND_DONE, rsp_tlast)
   // a full table gives no id
   `STE_ASSERT_IMP(a_full_no_id, rsp_tvalid && rsp_tdata[109],
      rsp_tuser == KIND_NEW_ID && rsp_tdata[31:0] == 32'd0)

endmodule

bind session_timeout_table_unit ste_checker u_ste_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for session_timeout_table_unit: a directed table of
// requests, then random traffic, each response checked against a behavioral
// table model. Depends on ste_pkg and the RTL only.
`timescale 1ns / 100ps

module tb;
   import ste_pkg::*;

   localparam int NDIR = 24;
   localparam int NRAND = 208;
   localparam int WATCHDOG = 20000;
   localparam int DRAIN = 8 * (TABLE_ENTRIES + 2);

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] id;
      logic [7:0]  func;
      logic [3:0]  owner;
      logic [63:0] data;
      logic        found;
      logic        full;
      logic        last;
   } rsp_t;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] sid;
      logic [7:0]  func;
      logic [3:0]  owner;
      logic [63:0] data;
      logic [31:0] now;
      bit          has_exp;
      rsp_t        exp;
   } req_t;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [111:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   // table model state
   bit          tbl_valid [TABLE_ENTRIES];
   logic [31:0] tbl_id [TABLE_ENTRIES];
   logic [7:0]  tbl_func [TABLE_ENTRIES];
   logic [3:0]  tbl_owner [TABLE_ENTRIES];
   logic [31:0] tbl_start [TABLE_ENTRIES];
   logic [63:0] tbl_data [TABLE_ENTRIES];
   logic [31:0] model_next_id;
   logic [15:0] model_max_age;

   rsp_t pending_rsp[$];
   int   errors = 0;
   int   idle_cycles = 0;
   bit   timed_out = 0;

   session_timeout_table_unit DUT (.*);

   always #5 clock = ~clock;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   function automatic int lookup(input logic [31:0] id);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic rsp_t mk(input logic [2:0] k);
      rsp_t r;
      r = '0;
      r.kind = k;
      r.last = 1;
      return r;
   endfunction

   // apply one request to the model and queue its responses
   task automatic predict_table(input req_t q);
      int   s;
      int   best;
      rsp_t r;
      case (q.action)
         ACT_ALLOC: begin
            r = mk(KIND_NEW_ID);
            s = lookup(model_next_id);
            if (s < 0)
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (!tbl_valid[i]) begin
                     s = i;
                     break;
                  end
            if (s < 0) r.full = 1;
            else begin
               r.id = model_next_id;
               tbl_valid[s] = 1;
               tbl_id[s] = model_next_id;
               tbl_func[s] = q.func;
               tbl_owner[s] = q.owner;
               tbl_start[s] = q.now;
               tbl_data[s] = '0;
               model_next_id = (model_next_id == '1) ? FIRST_ID : model_next_id + 1;
            end
            pending_rsp.push_back(r);
         end
         ACT_DELETE: begin
            r = mk(KIND_DELETED);
            s = lookup(q.sid);
            if (s >= 0) begin
               tbl_valid[s] = 0;
               r.found = 1;
            end
            pending_rsp.push_back(r);
         end
         ACT_STORE: begin
            r = mk(KIND_STORE);
            s = lookup(q.sid);
            if (s >= 0) begin
               tbl_data[s] = q.data;
               r.found = 1;
            end
            pending_rsp.push_back(r);
         end
         ACT_GET: begin
            r = mk(KIND_GET);
            s = lookup(q.sid);
            if (s >= 0) begin
               r.found = 1;
               r.data = tbl_data[s];
            end
            pending_rsp.push_back(r);
         end
         ACT_TICK: begin
            // expired entries leave in ascending id order
            forever begin
               best = -1;
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (tbl_valid[i] && q.now > tbl_start[i] &&
                      (q.now - tbl_start[i]) > {16'd0, model_max_age})
                     if (best < 0 || tbl_id[i] < tbl_id[best]) best = i;
               if (best < 0) break;
               r = '0;
               r.kind = KIND_TIMEOUT;
               r.id = tbl_id[best];
               r.func = tbl_func[best];
               r.owner = tbl_owner[best];
               tbl_valid[best] = 0;
               pending_rsp.push_back(r);
            end
            pending_rsp.push_back(mk(KIND_DONE));
         end
         default: ;
      endcase
   endtask

   function automatic req_t rq(input logic [2:0] a, input logic [31:0] sid,
                               input logic [63:0] d, input logic [31:0] now);
      req_t q;
      q.action = a;
      q.sid = sid;
      q.func = 8'($urandom);
      q.owner = 4'($urandom);
      q.data = d;
      q.now = now;
      q.has_exp = 0;
      q.exp = '0;
      return q;
   endfunction

   function automatic req_t rq_exp(input req_t q, input rsp_t e);
      q.has_exp = 1;
      q.exp = e;
      return q;
   endfunction

   // response check and stall pattern
   always @(posedge clock) begin
      rsp_t got;
      rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.id = rsp_tdata[31:0];
         got.func = rsp_tdata[39:32];
         got.owner = rsp_tdata[43:40];
         got.data = rsp_tdata[107:44];
         got.found = rsp_tdata[108];
         got.full = rsp_tdata[109];
         got.last = rsp_tlast;
         if (pending_rsp.size() == 0)
            report("unexpected response", 64'(got.kind), 64'd0);
         else begin
            want = pending_rsp.pop_front();
            if (got.kind != want.kind) report("kind", 64'(got.kind), 64'(want.kind));
            if (got.id != want.id) report("result_id", 64'(got.id), 64'(want.id));
            if (got.func != want.func)
               report("result_func", 64'(got.func), 64'(want.func));
            if (got.owner != want.owner)
               report("result_owner", 64'(got.owner), 64'(want.owner));
            if (got.data != want.data) report("result_data", got.data, want.data);
            if (got.found != want.found)
               report("found", 64'(got.found), 64'(want.found));
            if (got.full != want.full) report("full_res", 64'(got.full), 64'(want.full));
            if (got.last != want.last) report("last", 64'(got.last), 64'(want.last));
         end
      end
      // stretches of full throughput alternate with random stalling
      if (($time / 4000) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   // watchdog on accepted transfers
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
         timed_out = 1;
         $display("session_timeout_table_unit regression: fail");
         $finish;
      end
   end

   // valid stays high from one request to the next unless a gap is drawn
   task automatic send(input req_t q);
      int gap;
      // gap before this request
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {4'd0, q.now, q.data, q.owner, q.func, q.sid};
      req_tuser <= q.action;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (q.has_exp) begin
         predict_table(q);
         if (pending_rsp[$] != q.exp) report("table entry prediction", 64'd0, 64'd1);
      end else predict_table(q);
   endtask

   task automatic drain_and_write(input logic [15:0] age);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_data <= age;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_max_age = age;
   endtask

   function automatic logic [31:0] pick_id();
      int n;
      // mostly live ids, sometimes near misses or any value
      n = $urandom_range(0, 9);
      if (n < 7) begin
         for (int t = 0; t < 8; t++) begin
            int i;
            i = $urandom_range(0, TABLE_ENTRIES - 1);
            if (tbl_valid[i]) return tbl_id[i];
         end
         return model_next_id - 1;
      end
      if (n == 7) return model_next_id;
      return $urandom;
   endfunction

   req_t dir_tab[NDIR];
   logic [31:0] clk_now;

   initial begin
      rsp_t e;
      req_t q;
      int   op;
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 0;
      model_next_id = FIRST_ID;
      model_max_age = MAX_AGE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      e = mk(KIND_GET);
      dir_tab[0] = rq_exp(rq(ACT_GET, 32'd1, '0, 0), e);
      e = mk(KIND_DELETED);
      dir_tab[1] = rq_exp(rq(ACT_DELETE, 32'hFFFF_FFFF, '0, 0), e);
      e = mk(KIND_STORE);
      dir_tab[2] = rq_exp(rq(ACT_STORE, 32'd0, '1, 0), e);
      e = mk(KIND_DONE);
      dir_tab[3] = rq_exp(rq(ACT_TICK, 0, '0, 32'hFFFF_FFFF), e);
      e = mk(KIND_NEW_ID);
      e.id = 32'd1;
      dir_tab[4] = rq_exp(rq(ACT_ALLOC, 0, '0, 32'd100), e);
      dir_tab[4].func = 8'hFF;
      dir_tab[4].owner = 4'hF;
      e.id = 32'd2;
      dir_tab[5] = rq_exp(rq(ACT_ALLOC, 0, '0, 32'hFFFF_FFF0), e);
      dir_tab[5].func = 8'h00;
      dir_tab[5].owner = 4'h0;
      dir_tab[6] = rq(ACT_STORE, 32'd1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      dir_tab[7] = rq(ACT_GET, 32'd1, '0, 0);
      dir_tab[8] = rq(ACT_STORE, 32'd2, 64'h5555_AAAA_0000_FFFF, 0);
      dir_tab[9] = rq(ACT_GET, 32'd2, '0, 0);
      dir_tab[10] = rq(ACT_TICK, 0, '0, 32'd110);     // age equal to limit
      dir_tab[11] = rq(ACT_TICK, 0, '0, 32'd50);      // clock behind start
      dir_tab[12] = rq(ACT_TICK, 0, '0, 32'd111);     // first one expires
      dir_tab[13] = rq(ACT_DELETE, 32'd2, '0, 0);
      dir_tab[14] = rq(ACT_DELETE, 32'd2, '0, 0);
      dir_tab[15] = rq(3'd5, 32'd3, '1, 0);            // unused codes
      dir_tab[16] = rq(3'd6, 32'd3, '1, 0);
      dir_tab[17] = rq(3'd7, 32'd3, '1, 0);
      for (int i = 18; i < NDIR; i++) dir_tab[i] = rq(ACT_ALLOC, 0, '0, 32'd200 + i);
      for (int i = 0; i < NDIR; i++) send(dir_tab[i]);

      // fill the table, overflow it, then time every entry out
      for (int i = 0; i < TABLE_ENTRIES + 2; i++) send(rq(ACT_ALLOC, 0, '0, 32'd300));
      send(rq(ACT_TICK, 0, '0, 32'hFFFF_FFFF));

      drain_and_write(16'hFFFF);
      for (int i = 0; i < 4; i++) send(rq(ACT_ALLOC, 0, '0, 32'd0));
      send(rq(ACT_TICK, 0, '0, 32'd65535));
      send(rq(ACT_TICK, 0, '0, 32'd65536));
      drain_and_write(16'd0);
      for (int i = 0; i < 3; i++) send(rq(ACT_ALLOC, 0, '0, 32'd7));
      send(rq(ACT_TICK, 0, '0, 32'd8));

      // random traffic in phases of max_age
      clk_now = 32'd1000;
      for (int ph = 0; ph < 4; ph++) begin
         drain_and_write(ph == 3 ? MAX_AGE_RESET : 16'($urandom_range(0, 40)));
         for (int n = 0; n < NRAND / 4; n++) begin
            clk_now = clk_now + $urandom_range(0, 12);
            op = $urandom_range(0, 99);
            if (op < 30) q = rq(ACT_ALLOC, 0, '0, clk_now - $urandom_range(0, 4));
            else if (op < 45) q = rq(ACT_DELETE, pick_id(), '0, $urandom);
            else if (op < 62) q = rq(ACT_STORE, pick_id(), {$urandom, $urandom}, $urandom);
            else if (op < 80) q = rq(ACT_GET, pick_id(), {$urandom, $urandom}, $urandom);
            else if (op < 96) q = rq(ACT_TICK, $urandom, {$urandom, $urandom}, clk_now);
            else q = rq(3'($urandom_range(5, 7)), $urandom, {$urandom, $urandom}, $urandom);
            send(q);
         end
      end

      // wrap the id counter: jump it via ids near the top is not possible
      // from outside, so wrap is covered only when reached naturally
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) $display("session_timeout_table_unit regression: pass");
      else $display("session_timeout_table_unit regression: fail");
      $finish;
   end

endmodule
